### sv/psd_pkg.sv
package psd_pkg;
  typedef enum logic [1:0] {
    REG_START = 2'd0,
    REG_END   = 2'd1,
    REG_INNER = 2'd2
  } region_e;
endpackage

### sv/psd_div.sv
module psd_div #(
  parameter int NUM_BITS = 50,
  parameter int Q_BITS   = 24,
  parameter int TAG_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [NUM_BITS-1:0] num_i,
  input  logic [NUM_BITS-1:0] den_i,
  input  logic [TAG_BITS-1:0] tag_i,
  output logic                valid_o,
  output logic [Q_BITS-1:0]   quot_o,
  output logic [TAG_BITS-1:0] tag_o
);
  // one restoring step per stage; num < den so rem stays below den
  logic [Q_BITS:0]                 vld_q;
  logic [Q_BITS:0][NUM_BITS-1:0]   rem_q;
  logic [Q_BITS:0][NUM_BITS-1:0]   den_q;
  logic [Q_BITS:0][Q_BITS-1:0]     quo_q;
  logic [Q_BITS:0][TAG_BITS-1:0]   tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else vld_q <= {vld_q[Q_BITS-1:0], valid_i};
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= num_i;
    den_q[0] <= den_i;
    quo_q[0] <= '0;
    tag_q[0] <= tag_i;
  end

  for (genvar i = 0; i < Q_BITS; i++) begin : g_step
    logic [NUM_BITS:0] sh;
    logic [NUM_BITS:0] df;
    assign sh = {rem_q[i], 1'b0};
    assign df = sh - {1'b0, den_q[i]};
    always_ff @(posedge clk_i) begin
      if (!df[NUM_BITS]) rem_q[i+1] <= df[NUM_BITS-1:0];
      else rem_q[i+1] <= sh[NUM_BITS-1:0];
      quo_q[i+1] <= {quo_q[i][Q_BITS-2:0], ~df[NUM_BITS]};
      den_q[i+1] <= den_q[i];
      tag_q[i+1] <= tag_q[i];
    end
  end

  assign valid_o = vld_q[Q_BITS];
  assign quot_o  = quo_q[Q_BITS];
  assign tag_o   = tag_q[Q_BITS];
endmodule

### sv/psd_sqrt.sv
module psd_sqrt #(
  parameter int R_BITS   = 25,
  parameter int TAG_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [2*R_BITS-1:0] rad_i,
  input  logic [TAG_BITS-1:0] tag_i,
  output logic                valid_o,
  output logic [R_BITS-1:0]   root_o,
  output logic [TAG_BITS-1:0] tag_o
);
  // one result bit per stage, digit-by-digit
  localparam int W = 2 * R_BITS;
  logic [R_BITS:0]                vld_q;
  logic [R_BITS:0][W-1:0]         rad_q;
  logic [R_BITS:0][R_BITS+1:0]    rem_q;
  logic [R_BITS:0][R_BITS-1:0]    rt_q;
  logic [R_BITS:0][TAG_BITS-1:0]  tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else vld_q <= {vld_q[R_BITS-1:0], valid_i};
  end

  always_ff @(posedge clk_i) begin
    rad_q[0] <= rad_i;
    rem_q[0] <= '0;
    rt_q[0]  <= '0;
    tag_q[0] <= tag_i;
  end

  for (genvar i = 0; i < R_BITS; i++) begin : g_step
    logic [R_BITS+1:0] sh;
    logic [R_BITS+1:0] tr;
    logic [R_BITS+1:0] df;
    assign sh = {rem_q[i][R_BITS-1:0], rad_q[i][W-1:W-2]};
    assign tr = {rt_q[i], 2'b01};
    assign df = sh - tr;
    always_ff @(posedge clk_i) begin
      rad_q[i+1] <= {rad_q[i][W-3:0], 2'b00};
      tag_q[i+1] <= tag_q[i];
      if (sh >= tr) begin
        rem_q[i+1] <= df;
        rt_q[i+1]  <= {rt_q[i][R_BITS-2:0], 1'b1};
      end else begin
        rem_q[i+1] <= sh;
        rt_q[i+1]  <= {rt_q[i][R_BITS-2:0], 1'b0};
      end
    end
  end

  assign valid_o = vld_q[R_BITS];
  assign root_o  = rt_q[R_BITS];
  assign tag_o   = tag_q[R_BITS];
endmodule

### sv/point_segment_distance.sv
// channel  | ports                                        | direction
// request  | start_i, busy_o, point/start/end _x/_y _i    | in, busy_o out
// result   | done_o, nearest_x/y_o, distance_o, region_o  | out
// One request per cycle; busy_o is always low. A request passes 3 front stages,
// RATIO_FRACTION_BITS + 1 divider stages (input stage, then one quotient bit each),
// 5 scale/round/square stages and COORD_BITS + 2 square root stages (input stage,
// then one root bit each). Reset clears only valid bits. done_o pulses for one cycle
// per result; no stalls.
module point_segment_distance #(
  parameter int COORD_BITS          = 24,
  parameter int RATIO_FRACTION_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  output logic                         done_o,
  output logic signed [COORD_BITS-1:0] nearest_x_o,
  output logic signed [COORD_BITS-1:0] nearest_y_o,
  output logic        [COORD_BITS:0]   distance_o,
  output psd_pkg::region_e             region_o
);
  import psd_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int DB = CB + 1;         // differences
  localparam int PB = 2 * DB;         // products
  localparam int SB = PB + 1;         // dot products
  localparam int FB = RATIO_FRACTION_BITS;
  localparam int PTB = 6 * CB + 2;
  localparam int TAGB = PTB + 2 * DB;
  localparam int NB = DB + FB + 2;    // scaled product

  assign busy_o = 1'b0;

  // stage 1: differences
  logic v1_q;
  logic signed [DB-1:0] vx_q, vy_q, wx_q, wy_q;
  logic signed [CB-1:0] px1_q, py1_q, sx1_q, sy1_q, ex1_q, ey1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= start_i;
  end
  always_ff @(posedge clk_i) begin
    vx_q <= DB'(end_x_i) - DB'(start_x_i);
    vy_q <= DB'(end_y_i) - DB'(start_y_i);
    wx_q <= DB'(point_x_i) - DB'(start_x_i);
    wy_q <= DB'(point_y_i) - DB'(start_y_i);
    px1_q <= point_x_i; py1_q <= point_y_i;
    sx1_q <= start_x_i; sy1_q <= start_y_i;
    ex1_q <= end_x_i;   ey1_q <= end_y_i;
  end

  // stage 2: products
  logic v2_q;
  logic signed [PB-1:0] pwx_q, pwy_q, pvx_q, pvy_q;
  logic signed [DB-1:0] vx2_q, vy2_q;
  logic signed [CB-1:0] px2_q, py2_q, sx2_q, sy2_q, ex2_q, ey2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    pwx_q <= PB'(wx_q) * PB'(vx_q);
    pwy_q <= PB'(wy_q) * PB'(vy_q);
    pvx_q <= PB'(vx_q) * PB'(vx_q);
    pvy_q <= PB'(vy_q) * PB'(vy_q);
    vx2_q <= vx_q; vy2_q <= vy_q;
    px2_q <= px1_q; py2_q <= py1_q; sx2_q <= sx1_q; sy2_q <= sy1_q;
    ex2_q <= ex1_q; ey2_q <= ey1_q;
  end

  // stage 3: dot products and region
  logic v3_q;
  logic signed [SB-1:0] c1_q, c2_q;
  logic signed [SB-1:0] c1_d, c2_d;
  region_e reg3_q;
  logic signed [DB-1:0] vx3_q, vy3_q;
  logic signed [CB-1:0] px3_q, py3_q, sx3_q, sy3_q, ex3_q, ey3_q;
  assign c1_d = SB'(pwx_q) + SB'(pwy_q);
  assign c2_d = SB'(pvx_q) + SB'(pvy_q);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    c1_q <= c1_d;
    c2_q <= c2_d;
    if (c1_d <= 0) reg3_q <= REG_START;
    else if (c2_d <= c1_d) reg3_q <= REG_END;
    else reg3_q <= REG_INNER;
    vx3_q <= vx2_q; vy3_q <= vy2_q;
    px3_q <= px2_q; py3_q <= py2_q; sx3_q <= sx2_q; sy3_q <= sy2_q;
    ex3_q <= ex2_q; ey3_q <= ey2_q;
  end

  // divider: non-interior items get a harmless 0/1
  logic [SB-1:0] num_d, den_d;
  logic [TAGB-1:0] tag_d, tag4;
  logic [FB-1:0] b4;
  logic v4;
  logic signed [DB-1:0] vx4, vy4;
  logic [PTB-1:0] pt4;
  assign num_d = (reg3_q == REG_INNER) ? c1_q : '0;
  assign den_d = (reg3_q == REG_INNER) ? c2_q : SB'(1);
  assign tag_d = {vx3_q, vy3_q, px3_q, py3_q, sx3_q, sy3_q, ex3_q, ey3_q, reg3_q};

  psd_div #(.NUM_BITS(SB), .Q_BITS(FB), .TAG_BITS(TAGB)) u_div (
    .clk_i, .rst_ni, .valid_i(v3_q), .num_i(num_d), .den_i(den_d), .tag_i(tag_d),
    .valid_o(v4), .quot_o(b4), .tag_o(tag4)
  );

  assign {vx4, vy4, pt4} = tag4;

  // stage 5: scale by ratio
  logic v5_q;
  logic signed [NB-1:0] tx_q, ty_q;
  logic [PTB-1:0] tag5_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else v5_q <= v4;
  end
  always_ff @(posedge clk_i) begin
    tx_q <= NB'(vx4) * $signed({2'b00, b4});
    ty_q <= NB'(vy4) * $signed({2'b00, b4});
    tag5_q <= pt4;
  end

  // stage 6: round and pick the nearest point
  logic v6_q;
  logic signed [CB-1:0] nx6_q, ny6_q, px6_q, py6_q;
  region_e reg6_q;
  logic signed [NB-1:0] rx, ry;
  logic signed [CB-1:0] px5, py5, sx5, sy5, ex5, ey5;
  region_e reg5;
  assign {px5, py5, sx5, sy5, ex5, ey5} = tag5_q[PTB-1:2];
  assign reg5 = region_e'(tag5_q[1:0]);
  assign rx = (tx_q + (NB'(1) <<< (FB - 1))) >>> FB;
  assign ry = (ty_q + (NB'(1) <<< (FB - 1))) >>> FB;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else v6_q <= v5_q;
  end
  always_ff @(posedge clk_i) begin
    unique case (reg5)
      REG_END: begin
        nx6_q <= ex5; ny6_q <= ey5;
      end
      REG_INNER: begin
        nx6_q <= sx5 + rx[CB-1:0]; ny6_q <= sy5 + ry[CB-1:0];
      end
      default: begin
        nx6_q <= sx5; ny6_q <= sy5;
      end
    endcase
    reg6_q <= reg5;
    px6_q <= px5; py6_q <= py5;
  end

  // stage 7: offsets, stage 8: squares, stage 9: sum
  logic v7_q, v8_q, v9_q;
  logic signed [DB-1:0] dx7_q, dy7_q;
  logic [PB-1:0] sqx8_q, sqy8_q;
  logic [PB-1:0] sum9_q;
  logic [3*CB+2:0] t7_q, t8_q, t9_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0; v8_q <= 1'b0; v9_q <= 1'b0;
    end else begin
      v7_q <= v6_q; v8_q <= v7_q; v9_q <= v8_q;
    end
  end
  always_ff @(posedge clk_i) begin
    dx7_q <= DB'(px6_q) - DB'(nx6_q);
    dy7_q <= DB'(py6_q) - DB'(ny6_q);
    t7_q <= {CB'(0), nx6_q, ny6_q, reg6_q, 1'b0};
    sqx8_q <= PB'(dx7_q) * PB'(dx7_q);
    sqy8_q <= PB'(dy7_q) * PB'(dy7_q);
    t8_q <= t7_q;
    sum9_q <= sqx8_q + sqy8_q;
    t9_q <= t8_q;
  end

  logic [3*CB+2:0] tagq;
  psd_sqrt #(.R_BITS(DB), .TAG_BITS(3*CB+3)) u_sqrt (
    .clk_i, .rst_ni, .valid_i(v9_q), .rad_i(sum9_q), .tag_i(t9_q),
    .valid_o(done_o), .root_o(distance_o), .tag_o(tagq)
  );

  assign nearest_x_o = tagq[2*CB+2:CB+3];
  assign nearest_y_o = tagq[CB+2:3];
  assign region_o    = region_e'(tagq[2:1]);
endmodule
